/* rtl/fnvh_pkg.sv */
// shared types, constants and helpers for the fnv-1a 64 float image hash
`default_nettype none

package fnvh_pkg;

  localparam int DIM_BITS   = 16;
  localparam int COUNT_BITS = 34;
  localparam int PX_BITS    = 2 * DIM_BITS;
  localparam int PX3_BITS   = PX_BITS + 2;
  localparam int CMP_BITS   = (PX3_BITS > COUNT_BITS) ? PX3_BITS : COUNT_BITS;
  localparam int PADDR_BITS = 3;

  localparam logic [63:0] FNV_BASIS       = 64'hcbf2_9ce4_8422_2325;
  // prime is 2^40 + 0x1b3
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1b3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_DIM  = 2'd1;
  localparam logic [1:0] ST_COUNT     = 2'd2;
  localparam logic [1:0] ST_NONFINITE = 2'd3;

  typedef struct packed {
    logic [31:0] component_bits;
    logic        last_component;
  } in_item_t;

  typedef struct packed {
    logic [63:0] frame_hash;
    logic [1:0]  frame_status;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       absorb;
    logic       from_pre;
    logic [3:0] idx;
    logic       mul_px;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] domain_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h52; // R
      3'd1:    b = 8'h45; // E
      3'd2:    b = 8'h52; // R
      3'd3:    b = 8'h47; // G
      3'd4:    b = 8'h42; // B
      3'd5:    b = 8'h01;
      3'd6:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] word32(input logic [DIM_BITS-1:0] v);
    logic [31:0] w;
    w = '0;
    w[DIM_BITS-1:0] = v;
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/fnvh_cfg.sv */
// apb-style register file holding image width and height
`default_nettype none

module fnvh_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fnvh_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [fnvh_pkg::DIM_BITS-1:0]   width_o,
  output logic      [fnvh_pkg::DIM_BITS-1:0]   height_o
);

  logic [fnvh_pkg::DIM_BITS-1:0] width_r, width_nxt;
  logic [fnvh_pkg::DIM_BITS-1:0] height_r, height_nxt;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      if (paddr[2]) begin
        height_nxt = pwdata[fnvh_pkg::DIM_BITS-1:0];
      end else begin
        width_nxt = pwdata[fnvh_pkg::DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign prdata   = paddr[2] ? fnvh_pkg::word32(height_r) : fnvh_pkg::word32(width_r);
  assign width_o  = width_r;
  assign height_o = height_r;

endmodule

`default_nettype wire

/* rtl/fnvh_ctrl.sv */
// sequencer: accept, preamble bytes, component bytes, pixel multiply, finish
`default_nettype none

module fnvh_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire fnvh_pkg::sts_t sts,
  output fnvh_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_PX   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       pre_done_r, pre_done_nxt;
  logic       ready;
  logic       acc;

  // next component may enter while the last byte of this one is absorbed
  assign ready = (state_r == S_IDLE) ||
                 ((state_r == S_COMP) && (step_r[1:0] == 2'd3) && !sts.last);
  assign acc      = in_valid && ready;
  assign in_stall = !ready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    pre_done_nxt = pre_done_r;
    cmd          = '0;
    cmd.accept   = acc;
    cmd.absorb   = (state_r == S_PRE) || (state_r == S_COMP);
    cmd.from_pre = (state_r == S_PRE);
    cmd.idx      = step_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          step_nxt  = 4'd0;
          state_nxt = pre_done_r ? S_COMP : S_PRE;
        end
      end
      S_PRE: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) begin
          step_nxt     = 4'd0;
          state_nxt    = S_COMP;
          pre_done_nxt = 1'b1;
        end
      end
      S_COMP: begin
        step_nxt = step_r + 4'd1;
        if (step_r[1:0] == 2'd3) begin
          step_nxt = 4'd0;
          if (sts.last) begin
            state_nxt = S_PX;
          end else if (acc) begin
            state_nxt = S_COMP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PX: begin
        cmd.mul_px = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish   = 1'b1;
          pre_done_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= 4'd0;
      pre_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      pre_done_r <= pre_done_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/fnvh_dp.sv */
// hash datapath: byte xor-multiply step, counters, status and result register
`default_nettype none

module fnvh_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fnvh_pkg::in_item_t            in_data,
  input  wire fnvh_pkg::cmd_t                cmd,
  output fnvh_pkg::sts_t                     sts,
  input  wire logic [fnvh_pkg::DIM_BITS-1:0] width_i,
  input  wire logic [fnvh_pkg::DIM_BITS-1:0] height_i,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output fnvh_pkg::out_item_t                out_data
);

  logic [63:0]                     hash_r, hash_nxt;
  logic [fnvh_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                            nonfinite_r, nonfinite_nxt;
  logic [31:0]                     word_r, word_nxt;
  logic                            last_r, last_nxt;
  logic [fnvh_pkg::PX_BITS-1:0]    px_r, px_nxt;
  logic                            out_valid_r, out_valid_nxt;
  fnvh_pkg::out_item_t             out_data_r, out_data_nxt;

  logic [31:0]                     w32, h32;
  logic [7:0]                      byte_v;
  logic [63:0]                     hx;
  logic [63:0]                     hash_step;
  logic [fnvh_pkg::PX3_BITS-1:0]   px3;
  logic [fnvh_pkg::CMP_BITS-1:0]   px3_cmp, count_cmp;
  logic [1:0]                      status;
  logic                            out_free;

  assign w32 = fnvh_pkg::word32(width_i);
  assign h32 = fnvh_pkg::word32(height_i);

  always_comb begin
    if (cmd.from_pre) begin
      case (cmd.idx[3:2])
        2'd0, 2'd1: byte_v = fnvh_pkg::domain_byte(cmd.idx[2:0]);
        2'd2:       byte_v = w32[8*cmd.idx[1:0] +: 8];
        default:    byte_v = h32[8*cmd.idx[1:0] +: 8];
      endcase
    end else begin
      byte_v = word_r[8*cmd.idx[1:0] +: 8];
    end
  end

  // multiply by the prime as a shift plus a 9-bit product
  assign hx        = hash_r ^ {56'd0, byte_v};
  assign hash_step = (hx << fnvh_pkg::FNV_PRIME_SHIFT) + (hx * fnvh_pkg::FNV_PRIME_LOW);

  assign px3       = fnvh_pkg::PX3_BITS'(px_r) + fnvh_pkg::PX3_BITS'({px_r, 1'b0});
  assign px3_cmp   = fnvh_pkg::CMP_BITS'(px3);
  assign count_cmp = fnvh_pkg::CMP_BITS'(count_r);

  always_comb begin
    if ((width_i == '0) || (height_i == '0)) begin
      status = fnvh_pkg::ST_ZERO_DIM;
    end else if ((count_r == fnvh_pkg::COUNT_MAX) || (px3_cmp != count_cmp)) begin
      status = fnvh_pkg::ST_COUNT;
    end else if (nonfinite_r) begin
      status = fnvh_pkg::ST_NONFINITE;
    end else begin
      status = fnvh_pkg::ST_OK;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    hash_nxt      = hash_r;
    count_nxt     = count_r;
    nonfinite_nxt = nonfinite_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    px_nxt        = px_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.absorb) begin
      hash_nxt = hash_step;
    end
    if (cmd.accept) begin
      // negative zero hashes as positive zero
      word_nxt = (in_data.component_bits == 32'h8000_0000) ? 32'd0 : in_data.component_bits;
      last_nxt = in_data.last_component;
      if (in_data.component_bits[30:23] == 8'hff) begin
        nonfinite_nxt = 1'b1;
      end
      if (count_r != fnvh_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.mul_px) begin
      px_nxt = fnvh_pkg::PX_BITS'(width_i) * fnvh_pkg::PX_BITS'(height_i);
    end
    if (cmd.finish) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.frame_status = status;
      out_data_nxt.frame_hash   = (status == fnvh_pkg::ST_OK) ? hash_r : 64'd0;
      hash_nxt                  = fnvh_pkg::FNV_BASIS;
      count_nxt                 = '0;
      nonfinite_nxt             = 1'b0;
      last_nxt                  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= fnvh_pkg::FNV_BASIS;
      count_r     <= '0;
      nonfinite_r <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      count_r     <= count_nxt;
      nonfinite_r <= nonfinite_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    px_r       <= px_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.last     = last_r;
  assign sts.out_free = out_free;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire

/* rtl/fnv1a64_float_image_hash_core.sv */
// top level of the fnv-1a 64 float image hash: registers, sequencer and datapath
// a frame's first component goes through accept, 16 preamble bytes and its four bytes,
//   later ones through their four bytes, one byte per cycle through one xor-multiply
// a last component then adds the pixel multiply and status; status waits while out_stall holds
// inside a frame the next component can be taken while the last byte of the one before is absorbed
// reset: synchronous active-low rst_n clears registers, hash and frame state
`default_nettype none

module fnv1a64_float_image_hash_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire fnvh_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output fnvh_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fnvh_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  logic [fnvh_pkg::DIM_BITS-1:0] width;
  logic [fnvh_pkg::DIM_BITS-1:0] height;
  fnvh_pkg::cmd_t                cmd;
  fnvh_pkg::sts_t                sts;

  fnvh_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height)
  );

  fnvh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fnvh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .width_i   (width),
    .height_i  (height),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/fnvh_chk.sv */
// port-level checker for the hash core, bound to the top level
`default_nettype none

module fnvh_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire fnvh_pkg::out_item_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // any error status carries a zero hash
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_status != fnvh_pkg::ST_OK) |-> out_data.frame_hash == 64'd0)
    else $error("error result with nonzero hash");

  // an accept is always followed by a stalled input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result is only produced while the input side is held off
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without the input being stalled");

endmodule

bind fnv1a64_float_image_hash_core fnvh_chk u_fnvh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the fnv-1a 64 float image hash core
`timescale 1ns / 100ps

module testbench;

  localparam logic [63:0] FNV_PRIME      = (64'd1 << fnvh_pkg::FNV_PRIME_SHIFT) + 64'h1b3;
  // domain tag bytes R E R G B 1 3 0, byte 0 in the low bits
  localparam logic [63:0] DOMAIN_TAG     = 64'h0003_0142_4752_4552;
  localparam int          REG_IMAGE_WIDTH  = 0;
  localparam int          REG_IMAGE_HEIGHT = 1;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RANDOM_ITEMS   = 1100;
  localparam int          MAX_PRINTS     = 40;
  localparam int          N_DIRECTED     = 26;

  typedef enum logic {ROW_COMP, ROW_DIMS} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] a;      // component bits, or width word
    logic [31:0] b;      // height word
    logic        last;
    logic        typed;  // expected result typed in below
    logic [1:0]  status;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  fnvh_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  fnvh_pkg::out_item_t             out_data;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [fnvh_pkg::PADDR_BITS-1:0] paddr     = '0;
  logic [31:0]                     pwdata    = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  // predictor copy of the block
  logic [63:0]                     hash_acc;
  logic [fnvh_pkg::COUNT_BITS-1:0] comp_count;
  logic                            preamble_seen;
  logic                            nonfinite_flag;
  logic [fnvh_pkg::DIM_BITS-1:0]   dim_width;
  logic [fnvh_pkg::DIM_BITS-1:0]   dim_height;

  fnvh_pkg::out_item_t pending_hashes[$];
  int        mismatch_count = 0;
  int        random_sent    = 0;
  int        quiet_cycles   = 0;
  int        in_idle_pct    = 34;
  int        out_idle_pct   = 66;

  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{ROW_COMP, 32'h3f80_0000, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_ZERO_DIM},
    '{ROW_DIMS, 32'hffff_0001, 32'habcd_0001, 1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h0000_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h8000_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h7f7f_ffff, 32'h0,         1'b1, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'hff80_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h0000_0001, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h8000_0000, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_NONFINITE},
    '{ROW_COMP, 32'h1234_5678, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_COUNT},
    '{ROW_COMP, 32'h3f00_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'hbf00_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h007f_ffff, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h0080_0000, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_COUNT},
    // dims change mid-frame: preamble keeps 1x1, count check sees 1x2
    '{ROW_COMP, 32'h4120_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_DIMS, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'hc049_0fdb, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h0040_0000, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h8000_0001, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'hfe7f_ffff, 32'h0,         1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h8000_0000, 32'h0,         1'b1, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_DIMS, 32'h0000_ffff, 32'hffff_ffff, 1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'hffff_ffff, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_COUNT},
    '{ROW_DIMS, 32'hffff_0000, 32'h0000_ffff, 1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h7f80_0000, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_ZERO_DIM},
    '{ROW_DIMS, 32'h0000_ffff, 32'h1234_0000, 1'b0, 1'b0, fnvh_pkg::ST_OK},
    '{ROW_COMP, 32'h7fc0_0000, 32'h0,         1'b1, 1'b1, fnvh_pkg::ST_ZERO_DIM}
  };

  fnv1a64_float_image_hash_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [63:0] mix_byte(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [63:0] mix_word(input logic [63:0] h, input logic [31:0] w);
    logic [63:0] r;
    r = h;
    for (int i = 0; i < 4; i++) r = mix_byte(r, w[8*i +: 8]);
    return r;
  endfunction

  function automatic void restart_frame();
    hash_acc       = fnvh_pkg::FNV_BASIS;
    comp_count     = '0;
    preamble_seen  = 1'b0;
    nonfinite_flag = 1'b0;
  endfunction

  // folds one component into the frame hash; returns 1 when a result is due
  function automatic bit fold_component(input logic [31:0] bits, input logic last,
                                        output fnvh_pkg::out_item_t res);
    logic [31:0] b;
    logic [63:0] px;
    logic [1:0]  st;
    bit          count_ok;
    b   = bits;
    res = '0;
    if (!preamble_seen) begin
      for (int i = 0; i < 8; i++) hash_acc = mix_byte(hash_acc, DOMAIN_TAG[8*i +: 8]);
      hash_acc      = mix_word(hash_acc, fnvh_pkg::word32(dim_width));
      hash_acc      = mix_word(hash_acc, fnvh_pkg::word32(dim_height));
      preamble_seen = 1'b1;
    end
    if (b[30:23] == 8'hff) nonfinite_flag = 1'b1;
    if (b == 32'h8000_0000) b = '0;
    hash_acc = mix_word(hash_acc, b);
    if (comp_count != fnvh_pkg::COUNT_MAX) comp_count++;
    if (!last) return 0;
    px = 64'(dim_width) * 64'(dim_height);
    if (dim_width == '0 || dim_height == '0) begin
      st = fnvh_pkg::ST_ZERO_DIM;
    end else begin
      count_ok = (comp_count != fnvh_pkg::COUNT_MAX)
                 && (px <= 64'(fnvh_pkg::COUNT_MAX) / 3)
                 && (px * 3 == 64'(comp_count));
      if (!count_ok) st = fnvh_pkg::ST_COUNT;
      else if (nonfinite_flag) st = fnvh_pkg::ST_NONFINITE;
      else st = fnvh_pkg::ST_OK;
    end
    res.frame_hash   = (st == fnvh_pkg::ST_OK) ? hash_acc : 64'd0;
    res.frame_status = st;
    restart_frame();
    return 1;
  endfunction

  task automatic send_component(input logic [31:0] bits, input logic last,
                                input logic typed, input logic [1:0] typed_status);
    fnvh_pkg::in_item_t  item;
    fnvh_pkg::out_item_t res;
    item.component_bits = bits;
    item.last_component = last;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_component(bits, last, res)) begin
      if (typed) begin
        res.frame_hash   = 64'd0;
        res.frame_status = typed_status;
      end
      pending_hashes.push_back(res);
    end
  endtask

  // sender holds off until every result is back and the core has gone quiet
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] value);
    logic [fnvh_pkg::PADDR_BITS-1:0] addr;
    logic [31:0]                     want;
    addr     = fnvh_pkg::PADDR_BITS'(idx * 4);
    want     = fnvh_pkg::word32(value[fnvh_pkg::DIM_BITS-1:0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) dim_width = value[fnvh_pkg::DIM_BITS-1:0];
    else dim_height = value[fnvh_pkg::DIM_BITS-1:0];
    // read back in a second transfer
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [31:0] w, input logic [31:0] h);
    wait_quiet();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [31:0] random_dim_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 39))
      0:       w[15:0] = 16'd0;
      1:       w[15:0] = 16'hffff;
      2:       w[15:0] = 16'($urandom_range(0, 65535));
      default: w[15:0] = 16'($urandom_range(1, 3));
    endcase
    return w;
  endfunction

  function automatic logic [31:0] random_component(input bit make_nonfinite);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 15))
      0:       r = 32'h8000_0000;
      1:       r = 32'h0;
      2:       r[30:23] = 8'h00;
      default: ;
    endcase
    if (make_nonfinite) r[30:23] = 8'hff;
    else if (r[30:23] == 8'hff) r[23] = 1'b0;
    return r;
  endfunction

  task automatic run_random_frame();
    int unsigned need;
    int unsigned len;
    int unsigned bad_at;
    int unsigned switch_at;
    bit          mid_switch;
    logic [31:0] nw;
    logic [31:0] nh;
    if ($urandom_range(0, 99) < 30) set_dims(random_dim_word(), random_dim_word());
    need       = dim_width * dim_height * 3;
    mid_switch = 1'b0;
    switch_at  = 0;
    nw         = $urandom;
    nh         = $urandom;
    if (need == 0 || need > 150) begin
      len = $urandom_range(1, 6);
    end else if ($urandom_range(0, 99) < 6) begin
      // new dims arrive mid-frame, the frame length matches the new ones
      mid_switch = 1'b1;
      nw[15:0]   = 16'($urandom_range(1, 3));
      nh[15:0]   = 16'($urandom_range(1, 3));
      len        = nw[15:0] * nh[15:0] * 3;
      switch_at  = $urandom_range(1, len - 1);
    end else if ($urandom_range(0, 99) < 80) begin
      len = need;
    end else begin
      len = $urandom_range(1, need + 4);
    end
    bad_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, len - 1) : len;
    for (int unsigned k = 0; k < len; k++) begin
      if (mid_switch && k == switch_at) set_dims(nw, nh);
      send_component(random_component(k == bad_at), k == len - 1, 1'b0, fnvh_pkg::ST_OK);
      random_sent++;
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin : check_results
    fnvh_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        flag_mismatch($sformatf("result %h/%0d with none expected",
                                out_data.frame_hash, out_data.frame_status));
      end else begin
        want = pending_hashes.pop_front();
        if (out_data.frame_hash !== want.frame_hash) begin
          flag_mismatch($sformatf("frame_hash %h, expected %h",
                                  out_data.frame_hash, want.frame_hash));
        end
        if (out_data.frame_status !== want.frame_status) begin
          flag_mismatch($sformatf("frame_status %0d, expected %0d",
                                  out_data.frame_status, want.frame_status));
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dim_width  = '0;
    dim_height = '0;
    restart_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_DIMS) begin
        set_dims(directed_rows[i].a, directed_rows[i].b);
      end else begin
        send_component(directed_rows[i].a, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].status);
      end
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin in_idle_pct = 34; out_idle_pct = 66; end
        1:       begin in_idle_pct = 66; out_idle_pct = 34; end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      while (random_sent < (p + 1) * RANDOM_ITEMS / 3) run_random_frame();
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
